// ===== hw/rtl/tlvfe_pkg.sv =====
package tlvfe_pkg;

    // fixed frame header size in bytes
    localparam int unsigned HEADER_BYTES = 12;

    localparam logic [3:0] HDR_LAST = 4'(HEADER_BYTES - 1);

    // config register indexes
    localparam logic [1:0] CFG_FRAME_MAGIC  = 2'd0;
    localparam logic [1:0] CFG_WANTED_TAG   = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_LEN = 2'd2;

    // record scan phases
    localparam logic [2:0] PH_TAG0 = 3'd0;
    localparam logic [2:0] PH_TAG1 = 3'd1;
    localparam logic [2:0] PH_LEN0 = 3'd2;
    localparam logic [2:0] PH_LEN1 = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_LEN_MISM  = 3'd2,
        ST_BAD_MAGIC = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_TRUNCATED = 3'd5
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] message_type;
        logic [31:0] frame_serial;
        logic [31:0] payload_length;
        logic [63:0] field_value;
        logic [15:0] value_length;
        logic [15:0] value_offset;
    } t_out_word;

    // record scanner state
    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] tag;
        logic [15:0] rlen;
        logic [15:0] vleft;
        logic        stopped;
        logic        found;
        logic [15:0] mlen;
    } t_scan_st;

endpackage

// ===== hw/rtl/tlvfe_rec_scan.sv =====
// One payload byte through the tag/length/value record walker.
module tlvfe_rec_scan import tlvfe_pkg::*; (
    input  t_scan_st    i_st,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_left,       // payload bytes left after this byte
    input  logic [15:0] i_wanted_tag,
    output t_scan_st    o_st,
    output logic        o_match
);

    logic [15:0] len_full;
    logic [15:0] vleft_dec;

    assign len_full  = {i_byte, i_st.rlen[7:0]};
    assign vleft_dec = (i_st.vleft != 16'd0) ? (i_st.vleft - 16'd1) : i_st.vleft;

    always_comb begin
        o_st    = i_st;
        o_match = 1'b0;
        case (i_st.phase)
            PH_TAG0: begin
                o_st.tag   = {8'h00, i_byte};
                o_st.phase = PH_TAG1;
            end
            PH_TAG1: begin
                o_st.tag   = {i_byte, i_st.tag[7:0]};
                o_st.phase = PH_LEN0;
            end
            PH_LEN0: begin
                o_st.rlen  = {8'h00, i_byte};
                o_st.phase = PH_LEN1;
            end
            PH_LEN1: begin
                o_st.rlen = len_full;
                if (i_left < 32'(len_full)) begin
                    // record overruns the payload
                    o_st.stopped = 1'b1;
                end else if (i_st.tag == i_wanted_tag) begin
                    o_st.found   = 1'b1;
                    o_st.stopped = 1'b1;
                    o_st.mlen    = len_full;
                    o_st.vleft   = len_full;
                    o_match      = 1'b1;
                end else if (len_full == 16'd0) begin
                    o_st.phase = PH_TAG0;
                end else begin
                    o_st.vleft = len_full;
                    o_st.phase = PH_SKIP;
                end
            end
            default: begin
                o_st.vleft = vleft_dec;
                if (vleft_dec == 16'd0) begin
                    o_st.phase = PH_TAG0;
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/tlv_frame_field_extractor.sv =====
// Channel   Dir  Handshake                  Word
// --------  ---  -------------------------  -------------------------------------
// in        in   i_in_valid / o_in_ready    t_in_word: mode, data_byte
// out       out  o_out_valid / i_out_ready  t_out_word: status, header, value
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data (always ready)
//
// One input word per cycle; its result, if any, shows on the out register the
// cycle after acceptance. The frame state and the out register are updated in
// the same edge from one pass of logic on the accepted byte.
// o_in_ready drops only while a result sits unread and i_out_ready is low.
// Reset (synchronous, active low) clears the config registers, frame state,
// the drop flag and out valid.
module tlv_frame_field_extractor import tlvfe_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // payload counters hold 0..MAX_PAYLOAD
    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

    // config
    logic [15:0] r_frame_magic;
    logic [15:0] r_wanted_tag;
    logic [3:0]  r_expected_len;

    // frame state
    logic [3:0]    r_hdr_idx,  n_hdr_idx;
    logic [15:0]   r_magic,    n_magic;
    logic [15:0]   r_type,     n_type;
    logic [31:0]   r_len,      n_len;
    logic [31:0]   r_serial,   n_serial;
    logic [CW-1:0] r_left,     n_left;
    logic [CW-1:0] r_pos,      n_pos;
    t_scan_st      r_scan,     n_scan;
    logic [3:0]    r_taken,    n_taken;
    logic [63:0]   r_mval,     n_mval;
    logic [CW-1:0] r_moff,     n_moff;
    logic          r_drop,     n_drop;

    // out register
    logic          r_out_valid;
    t_out_word     r_out_data;
    t_out_word     n_res;
    logic          n_emit;

    t_scan_st      w_scan_nxt;
    logic          w_match;
    logic [CW-1:0] w_left_dec;  // payload bytes left after this byte
    logic          in_acc;
    logic          clr;
    logic          fin;     // payload done: report match result

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign in_acc      = i_in_valid && o_in_ready;
    assign w_left_dec  = (r_left != '0) ? (r_left - CW'(1)) : r_left;

    tlvfe_rec_scan u_scan (
        .i_st         (r_scan),
        .i_byte       (i_in_data.data_byte),
        .i_left       (32'(w_left_dec)),
        .i_wanted_tag (r_wanted_tag),
        .o_st         (w_scan_nxt),
        .o_match      (w_match)
    );

    always_comb begin
        n_hdr_idx = r_hdr_idx;
        n_magic   = r_magic;
        n_type    = r_type;
        n_len     = r_len;
        n_serial  = r_serial;
        n_left    = r_left;
        n_pos     = r_pos;
        n_scan    = r_scan;
        n_taken   = r_taken;
        n_mval    = r_mval;
        n_moff    = r_moff;
        n_drop    = r_drop;
        clr       = 1'b0;
        fin       = 1'b0;
        n_emit    = 1'b0;
        n_res     = '0;

        if (i_in_data.mode) begin
            // connection closed
            if (r_drop) begin
                n_drop = 1'b0;
                clr    = 1'b1;
            end else if (r_hdr_idx != 4'd0) begin
                n_emit       = 1'b1;
                n_res.status = ST_TRUNCATED;
                clr          = 1'b1;
            end
        end else if (!r_drop) begin
            if (r_hdr_idx < 4'(HEADER_BYTES)) begin
                case (r_hdr_idx)
                    4'd0:                      n_magic[7:0]  = i_in_data.data_byte;
                    4'd1:                      n_magic[15:8] = i_in_data.data_byte;
                    4'd2, 4'd3:
                        n_type[8*r_hdr_idx[0] +: 8]       = i_in_data.data_byte;
                    4'd4, 4'd5, 4'd6, 4'd7:
                        n_len[8*r_hdr_idx[1:0] +: 8]      = i_in_data.data_byte;
                    default:
                        n_serial[8*r_hdr_idx[1:0] +: 8]   = i_in_data.data_byte;
                endcase
                n_hdr_idx = r_hdr_idx + 4'd1;
                if (r_hdr_idx == HDR_LAST) begin
                    if (n_magic != r_frame_magic) begin
                        n_emit       = 1'b1;
                        n_res.status = ST_BAD_MAGIC;
                        clr          = 1'b1;
                        n_drop       = 1'b1;
                    end else if (33'(n_len) > 33'(MAX_PAYLOAD)) begin
                        n_emit       = 1'b1;
                        n_res.status = ST_TOO_LONG;
                        clr          = 1'b1;
                        n_drop       = 1'b1;
                    end else if (n_len == 32'd0) begin
                        n_emit       = 1'b1;
                        n_res.status = ST_ABSENT;
                        clr          = 1'b1;
                    end else begin
                        n_left = CW'(n_len);
                        n_pos  = '0;
                    end
                end
            end else begin
                // payload byte
                n_left = w_left_dec;
                n_pos  = r_pos + CW'(1);
                if (r_scan.found) begin
                    if (r_scan.vleft != 16'd0) begin
                        if (!r_taken[3]) begin
                            n_mval[8*r_taken[2:0] +: 8] = i_in_data.data_byte;
                            n_taken = r_taken + 4'd1;
                        end
                        n_scan.vleft = r_scan.vleft - 16'd1;
                    end
                end else if (!r_scan.stopped) begin
                    n_scan = w_scan_nxt;
                    if (w_match) begin
                        n_moff = r_pos + CW'(1);
                    end
                end
                if (n_left == '0) begin
                    fin    = 1'b1;
                    n_emit = 1'b1;
                    clr    = 1'b1;
                end
            end
        end

        if (fin) begin
            if (n_scan.found) begin
                n_res.value_length = n_scan.mlen;
                n_res.value_offset = 16'(n_moff);
                if (r_expected_len != 4'd0 && n_scan.mlen != {12'd0, r_expected_len}) begin
                    n_res.status = ST_LEN_MISM;
                end else begin
                    n_res.status      = ST_FOUND;
                    n_res.field_value = n_mval;
                end
            end else begin
                n_res.status = ST_ABSENT;
            end
        end
        n_res.message_type   = n_type;
        n_res.frame_serial   = n_serial;
        n_res.payload_length = n_len;

        if (clr) begin
            n_hdr_idx = '0;
            n_magic   = '0;
            n_type    = '0;
            n_len     = '0;
            n_serial  = '0;
            n_left    = '0;
            n_pos     = '0;
            n_scan    = '0;
            n_taken   = '0;
            n_mval    = '0;
            n_moff    = '0;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_magic  <= '0;
            r_wanted_tag   <= '0;
            r_expected_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_MAGIC:  r_frame_magic  <= i_cfg_data;
                CFG_WANTED_TAG:   r_wanted_tag   <= i_cfg_data;
                CFG_EXPECTED_LEN: r_expected_len <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= '0;
            r_magic   <= '0;
            r_type    <= '0;
            r_len     <= '0;
            r_serial  <= '0;
            r_left    <= '0;
            r_pos     <= '0;
            r_scan    <= '0;
            r_taken   <= '0;
            r_mval    <= '0;
            r_moff    <= '0;
            r_drop    <= 1'b0;
        end else if (in_acc) begin
            r_hdr_idx <= n_hdr_idx;
            r_magic   <= n_magic;
            r_type    <= n_type;
            r_len     <= n_len;
            r_serial  <= n_serial;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_scan    <= n_scan;
            r_taken   <= n_taken;
            r_mval    <= n_mval;
            r_moff    <= n_moff;
            r_drop    <= n_drop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out_data <= n_res;
        end
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    import tlvfe_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 65536;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned WORDS_PER_PHASE = 285;
    localparam int unsigned NUM_PHASES = 6;

    // input word kinds
    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    localparam t_out_word NO_RESULT = '0;
    // close after magic and the low type byte
    localparam t_out_word WANT_TRUNC = '{status: ST_TRUNCATED, message_type: 16'h00FF,
                                         default: '0};
    // all-ones header against the reset magic of zero
    localparam t_out_word WANT_BAD_MAGIC = '{status: ST_BAD_MAGIC, message_type: 16'hFFFF,
                                             frame_serial: '1, payload_length: '1,
                                             default: '0};

    typedef struct packed {
        logic      typed;
        t_in_word  word;
        t_out_word want;
    } t_script_row;

    localparam int SCRIPT_LEN = 19;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, '{MODE_CLOSE, 8'h00}, NO_RESULT},      // close while idle
        '{1'b0, '{MODE_BYTE, 8'h00}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'h00}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b1, '{MODE_CLOSE, 8'hFF}, WANT_TRUNC},     // close inside the header
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b0, '{MODE_BYTE, 8'hFF}, NO_RESULT},
        '{1'b1, '{MODE_BYTE, 8'hFF}, WANT_BAD_MAGIC},  // bad magic wins over length
        '{1'b0, '{MODE_BYTE, 8'h00}, NO_RESULT},       // dropped
        '{1'b0, '{MODE_CLOSE, 8'h00}, NO_RESULT}       // close while dropping
    };

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_word    in_word = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_word   o_out_data;
    logic        o_cfg_ready;

    always #5 i_clk = ~i_clk;

    tlv_frame_field_extractor #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Extractor model: registers, frame state and the per-word update
    // ------------------------------------------------------------------
    logic [15:0] cfg_magic, cfg_tag;
    logic [3:0]  cfg_vlen;

    int unsigned hdr_idx;
    logic [15:0] hdr_magic, hdr_type;
    logic [31:0] hdr_len, hdr_serial;
    logic [16:0] pay_left, pay_pos;
    logic [2:0]  rec_phase;
    logic [15:0] rec_tag, rec_len, val_left;
    bit          scan_done, hit, dropping;
    logic [3:0]  hit_taken;
    logic [63:0] hit_value;
    logic [15:0] hit_len;
    logic [16:0] hit_off;

    t_out_word   pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned live_words;
    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 51;
    bit          send_burst = 1'b0;
    logic [7:0]  frame_bytes[$];

    function automatic void frame_clear();
        hdr_idx = 0;  hdr_magic = '0; hdr_type = '0;  hdr_len = '0;  hdr_serial = '0;
        pay_left = '0; pay_pos = '0;  rec_phase = PH_TAG0; rec_tag = '0; rec_len = '0;
        val_left = '0; scan_done = 0; hit = 0; hit_taken = '0; hit_value = '0;
        hit_len = '0;  hit_off = '0;
    endfunction

    function automatic t_out_word frame_result(t_status st, logic [63:0] val,
                                               logic [15:0] vlen, logic [15:0] voff);
        t_out_word r;
        r.status         = st;
        r.message_type   = hdr_type;
        r.frame_serial   = hdr_serial;
        r.payload_length = hdr_len;
        r.field_value    = val;
        r.value_length   = vlen;
        r.value_offset   = voff;
        return r;
    endfunction

    // verdict at payload end, then back to idle
    function automatic t_out_word lookup_verdict();
        t_out_word r;
        if (!hit)
            r = frame_result(ST_ABSENT, '0, '0, '0);
        else if (cfg_vlen != 0 && hit_len != cfg_vlen)
            r = frame_result(ST_LEN_MISM, '0, hit_len, hit_off[15:0]);
        else
            r = frame_result(ST_FOUND, hit_value, hit_len, hit_off[15:0]);
        frame_clear();
        return r;
    endfunction

    // returns 1 when the word yields a result, placed in r
    function automatic bit extract_word(input t_in_word w, output t_out_word r);
        logic [7:0]  b;
        logic [16:0] pos;
        b = w.data_byte;
        r = '0;
        if (w.mode == MODE_CLOSE) begin
            if (dropping) begin
                dropping = 0;
                frame_clear();
                return 0;
            end
            if (hdr_idx == 0) return 0;
            r = frame_result(ST_TRUNCATED, '0, '0, '0);
            frame_clear();
            return 1;
        end
        if (dropping) return 0;

        if (hdr_idx < HEADER_BYTES) begin
            if (hdr_idx < 2)      hdr_magic[8*hdr_idx +: 8] = b;
            else if (hdr_idx < 4) hdr_type[8*(hdr_idx-2) +: 8] = b;
            else if (hdr_idx < 8) hdr_len[8*(hdr_idx-4) +: 8] = b;
            else                  hdr_serial[8*(hdr_idx-8) +: 8] = b;
            hdr_idx++;
            if (hdr_idx < HEADER_BYTES) return 0;
            if (hdr_magic != cfg_magic) begin
                r = frame_result(ST_BAD_MAGIC, '0, '0, '0);
                frame_clear();
                dropping = 1;
                return 1;
            end
            if (hdr_len > MAX_PAYLOAD) begin
                r = frame_result(ST_TOO_LONG, '0, '0, '0);
                frame_clear();
                dropping = 1;
                return 1;
            end
            if (hdr_len == 0) begin
                r = lookup_verdict();
                return 1;
            end
            pay_left = hdr_len[16:0];
            pay_pos  = '0;
            return 0;
        end

        pos = pay_pos;
        if (pay_left > 0) pay_left--;
        pay_pos = pay_pos + 17'd1;
        if (hit) begin
            // collect up to eight value bytes of the matched record
            if (val_left > 0) begin
                if (hit_taken < 8) begin
                    hit_value[8*hit_taken +: 8] = b;
                    hit_taken++;
                end
                val_left--;
            end
        end else if (!scan_done) begin
            case (rec_phase)
                PH_TAG0: begin
                    rec_tag = {8'h00, b};
                    rec_phase = PH_TAG1;
                end
                PH_TAG1: begin
                    rec_tag[15:8] = b;
                    rec_phase = PH_LEN0;
                end
                PH_LEN0: begin
                    rec_len = {8'h00, b};
                    rec_phase = PH_LEN1;
                end
                PH_LEN1: begin
                    rec_len[15:8] = b;
                    if (pay_left < rec_len) begin
                        scan_done = 1;              // record runs past the payload
                    end else if (rec_tag == cfg_tag) begin
                        hit = 1;
                        scan_done = 1;
                        hit_len = rec_len;
                        hit_off = pos + 17'd1;
                        val_left = rec_len;
                    end else if (rec_len == 0) begin
                        rec_phase = PH_TAG0;
                    end else begin
                        val_left = rec_len;
                        rec_phase = PH_SKIP;
                    end
                end
                default: begin
                    if (val_left > 0) val_left--;
                    if (val_left == 0) rec_phase = PH_TAG0;
                end
            endcase
        end
        if (pay_left == 0) begin
            r = lookup_verdict();
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word r;
        bit        got;
        bit        counts;
        while (!send_burst && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        // dropped bytes and idle closes do not count as real traffic
        counts = !(dropping || (w.mode == MODE_CLOSE && hdr_idx == 0));
        got = extract_word(w, r);
        if (counts) live_words++;
        if (typed) pending_results.push_back(want);
        else if (got) pending_results.push_back(r);
    endtask

    task automatic send_close();
        send_word('{MODE_CLOSE, 8'($urandom)}, 1'b0, NO_RESULT);
    endtask

    task automatic send_frame_bytes(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_word('{MODE_BYTE, frame_bytes[i]}, 1'b0, NO_RESULT);
    endtask

    // sender holds off until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_MAGIC:  cfg_magic = val;
            CFG_WANTED_TAG:   cfg_tag = val;
            CFG_EXPECTED_LEN: cfg_vlen = val[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] magic, input logic [15:0] tag,
                             input logic [3:0] vlen);
        drain_results();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_FRAME_MAGIC, magic);
        write_reg(CFG_WANTED_TAG, tag);
        write_reg(CFG_EXPECTED_LEN, {12'h000, vlen});
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_header(input logic [15:0] magic, input logic [31:0] len);
        put_le(magic, 2);
        put_le($urandom, 2);
        put_le(len, 4);
        put_le($urandom, 4);
    endfunction

    // length field is patched once the payload is laid down
    function automatic void patch_length();
        logic [31:0] plen;
        plen = frame_bytes.size() - HEADER_BYTES;
        for (int i = 0; i < 4; i++) frame_bytes[4+i] = plen[8*i +: 8];
    endfunction

    function automatic void put_record(input logic [15:0] tag, input int vlen, input int sent);
        put_le(tag, 2);
        put_le(vlen, 2);
        for (int i = 0; i < sent; i++) frame_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] pick_tag();
        return ($urandom_range(0, 2) == 0) ? cfg_tag : 16'($urandom);
    endfunction

    // well-formed frame: a few records, sometimes a short tail or an overrun
    function automatic void build_good_frame();
        int nrec;
        int vlen;
        frame_bytes.delete();
        put_header(cfg_magic, 0);
        nrec = $urandom_range(0, 4);
        for (int r = 0; r < nrec; r++) begin
            case ($urandom_range(0, 3))
                0:       vlen = cfg_vlen;
                1:       vlen = $urandom_range(0, 3);
                2:       vlen = $urandom_range(4, 12);
                default: vlen = $urandom_range(9, 24);
            endcase
            put_record(pick_tag(), vlen, vlen);
        end
        if ($urandom_range(0, 5) == 0) begin
            vlen = $urandom_range(5, 40);
            put_record(pick_tag(), vlen, $urandom_range(0, vlen - 1));
        end else if ($urandom_range(0, 3) == 0) begin
            put_le($urandom, $urandom_range(1, 3));
        end
        patch_length();
    endfunction

    task automatic send_random_frame();
        int unsigned kind;
        logic [31:0] long_len;
        kind = $urandom_range(0, 99);
        send_burst = ($urandom_range(0, 7) == 0);
        if (kind < 58) begin
            build_good_frame();
            send_frame_bytes(frame_bytes.size());
        end else if (kind < 70) begin
            build_good_frame();
            send_frame_bytes($urandom_range(1, frame_bytes.size() - 1));
            send_close();
        end else if (kind < 78) begin
            frame_bytes.delete();
            put_header(cfg_magic ^ 16'($urandom_range(1, 65535)), $urandom_range(0, 40));
            put_le($urandom, $urandom_range(0, 4));
            send_frame_bytes(frame_bytes.size());
            send_close();
        end else if (kind < 85) begin
            case ($urandom_range(0, 2))
                0:       long_len = MAX_PAYLOAD + 1;
                1:       long_len = 32'hFFFF_FFFF;
                default: long_len = $urandom_range(32'hFFFF_FFFF, MAX_PAYLOAD + 1);
            endcase
            frame_bytes.delete();
            put_header(cfg_magic, long_len);
            put_le($urandom, $urandom_range(0, 4));
            send_frame_bytes(frame_bytes.size());
            send_close();
        end else if (kind < 90) begin
            send_close();
        end else begin
            frame_bytes.delete();
            for (int i = $urandom_range(1, 20); i > 0; i--) frame_bytes.push_back(8'($urandom));
            send_frame_bytes(frame_bytes.size());
            send_close();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and field-by-field compare
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_side
        t_out_word want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending, status", o_out_data.status, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status != want.status)
                    note_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.message_type != want.message_type)
                    note_mismatch("message_type", o_out_data.message_type, want.message_type);
                if (o_out_data.frame_serial != want.frame_serial)
                    note_mismatch("frame_serial", o_out_data.frame_serial, want.frame_serial);
                if (o_out_data.payload_length != want.payload_length)
                    note_mismatch("payload_length", o_out_data.payload_length,
                                  want.payload_length);
                if (o_out_data.field_value != want.field_value)
                    note_mismatch("field_value", o_out_data.field_value, want.field_value);
                if (o_out_data.value_length != want.value_length)
                    note_mismatch("value_length", o_out_data.value_length, want.value_length);
                if (o_out_data.value_offset != want.value_offset)
                    note_mismatch("value_offset", o_out_data.value_offset, want.value_offset);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned frames;
        int unsigned i;
        cfg_magic = '0;
        cfg_tag   = '0;
        cfg_vlen  = '0;
        dropping  = 0;
        frame_clear();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < SCRIPT_LEN; i++)
            send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].want);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // receiver-light first, then sender-light, then full rate
            case (phase / 2)
                0:       begin send_idle_pct = 24; recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (phase)
                0: ;    // reset values
                1: configure(16'hFFFF, 16'hFFFF, 4'd8);
                2: configure(16'($urandom), 16'($urandom), 4'($urandom_range(1, 7)));
                3: configure(16'($urandom), 16'h0000, 4'd0);
                4: configure(16'h0000, 16'($urandom), 4'd8);
                default: configure(16'($urandom), 16'($urandom), 4'($urandom_range(0, 8)));
            endcase
            live_words = 0;
            frames = 0;
            while (live_words < WORDS_PER_PHASE) begin
                send_random_frame();
                frames++;
                if (frames % 40 == 39) drain_results();
            end
            send_close();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== tlv_frame_field_extractor.f =====
hw/rtl/tlvfe_pkg.sv
hw/rtl/tlvfe_rec_scan.sv
hw/rtl/tlv_frame_field_extractor.sv
test/testbench.sv
